// File: rtl/b64c_pkg.sv
package b64c_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_CHAR  = 2'd1;

  // Direction codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_RESET = 8'h3d;  // '='

  // Character codes of the alphabet range bounds
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_SLASH   = 8'h2f;

  // Group queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // One finished group: up to four result bytes
  typedef struct packed {
    logic [3:0][7:0] data;      // data[0] goes out first
    logic [1:0]      last_idx;  // index of the final beat
    logic            msg_end;
  } grp_t;

  // Map a 6-bit value to its alphabet character
  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] r;
    begin
      if (v < 6'd26) begin
        r = CH_UPPER_A + {2'b00, v};
      end else if (v < 6'd52) begin
        r = CH_LOWER_A + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
        r = CH_DIGIT_0 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
        r = CH_PLUS;
      end else begin
        r = CH_SLASH;
      end
      return r;
    end
  endfunction

  // Map a character to {valid, 6-bit value}
  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    begin
      t = 8'd0;
      r = 7'd0;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
        t = c - CH_UPPER_A;
        r = {1'b1, t[5:0]};
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
        t = c - CH_LOWER_A + 8'd26;
        r = {1'b1, t[5:0]};
      end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
        t = c - CH_DIGIT_0 + 8'd52;
        r = {1'b1, t[5:0]};
      end else if (c == CH_PLUS) begin
        r = {1'b1, 6'd62};
      end else if (c == CH_SLASH) begin
        r = {1'b1, 6'd63};
      end
      return r;
    end
  endfunction

endpackage

// File: rtl/b64c_front.sv
module b64c_front
  import b64c_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 in_message_end,
  input  logic                 q_full,
  output logic                 push,
  output grp_t                 push_grp
);

  logic        direction_r, direction_nxt;
  logic [7:0]  pad_r, pad_nxt;
  logic [23:0] buf_r, buf_nxt;
  logic [1:0]  fill_r, fill_nxt;
  logic        inv_r, inv_nxt;
  logic        twp_r, twp_nxt;

  logic        accept;
  logic        emit;
  logic [1:0]  enc_n;
  logic [23:0] enc_buf, enc_v;
  logic        dec_pad;
  logic [6:0]  dec_sx;
  logic        dec_inv, dec_twp;
  logic [23:0] dec_buf;

  assign accept = in_valid && !q_full;

  // Classify the beat and build the next group state
  always_comb begin
    direction_nxt = direction_r;
    pad_nxt       = pad_r;
    buf_nxt       = buf_r;
    fill_nxt      = fill_r;
    inv_nxt       = inv_r;
    twp_nxt       = twp_r;
    emit          = 1'b0;
    push_grp      = '0;
    push_grp.msg_end = in_message_end;

    enc_buf = {buf_r[15:0], in_byte};
    enc_n   = (fill_r == 2'd2 || fill_r == 2'd3) ? 2'd3 : fill_r + 2'd1;
    case (enc_n)
      2'd1:    enc_v = {enc_buf[7:0], 16'd0};
      2'd2:    enc_v = {enc_buf[15:0], 8'd0};
      default: enc_v = enc_buf;
    endcase

    dec_pad = (fill_r[1] == 1'b1) && (in_byte == pad_r);
    dec_sx  = char_to_sextet(in_byte);
    dec_inv = inv_r || (!dec_pad && !dec_sx[6]);
    dec_twp = (fill_r == 2'd2) ? dec_pad : twp_r;
    dec_buf = {buf_r[17:0], (dec_pad || !dec_sx[6]) ? 6'd0 : dec_sx[5:0]};

    if (accept) begin
      if (direction_r == DIR_ENCODE) begin
        // Gather three bytes, or fewer at a message end, and emit four characters
        buf_nxt = enc_buf;
        if (enc_n != 2'd3 && !in_message_end) begin
          fill_nxt = enc_n;
        end else begin
          emit = 1'b1;
          push_grp.data[0] = sextet_to_char(enc_v[23:18]);
          push_grp.data[1] = sextet_to_char(enc_v[17:12]);
          push_grp.data[2] = (enc_n != 2'd1) ? sextet_to_char(enc_v[11:6]) : pad_r;
          push_grp.data[3] = (enc_n == 2'd3) ? sextet_to_char(enc_v[5:0]) : pad_r;
          push_grp.last_idx = 2'd3;
          buf_nxt  = '0;
          fill_nxt = '0;
          inv_nxt  = 1'b0;
          twp_nxt  = 1'b0;
        end
      end else begin
        // Gather four characters, emit one to three bytes
        buf_nxt = dec_buf;
        inv_nxt = dec_inv;
        twp_nxt = dec_twp;
        if (fill_r != 2'd3) begin
          if (in_message_end) begin
            buf_nxt = '0;
            fill_nxt = '0;
            inv_nxt = 1'b0;
            twp_nxt = 1'b0;
          end else begin
            fill_nxt = fill_r + 2'd1;
          end
        end else begin
          emit = !dec_inv;
          push_grp.data[0] = dec_buf[23:16];
          push_grp.data[1] = dec_buf[15:8];
          push_grp.data[2] = dec_buf[7:0];
          push_grp.data[3] = 8'd0;
          push_grp.last_idx = dec_twp ? 2'd0 : (dec_pad ? 2'd1 : 2'd2);
          buf_nxt  = '0;
          fill_nxt = '0;
          inv_nxt  = 1'b0;
          twp_nxt  = 1'b0;
        end
      end
    end

    // Register writes; a direction change restarts the group
    if (cfg_we) begin
      case (cfg_index)
        CFG_DIRECTION: begin
          direction_nxt = cfg_wdata[0];
          buf_nxt  = '0;
          fill_nxt = '0;
          inv_nxt  = 1'b0;
          twp_nxt  = 1'b0;
        end
        CFG_PAD_CHAR: pad_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  assign push = accept && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
      pad_r       <= PAD_RESET;
      buf_r       <= '0;
      fill_r      <= '0;
      inv_r       <= 1'b0;
      twp_r       <= 1'b0;
    end else begin
      direction_r <= direction_nxt;
      pad_r       <= pad_nxt;
      buf_r       <= buf_nxt;
      fill_r      <= fill_nxt;
      inv_r       <= inv_nxt;
      twp_r       <= twp_nxt;
    end
  end

endmodule

// File: rtl/b64c_queue.sv
module b64c_queue
  import b64c_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  grp_t              push_grp,
  input  logic              pop,
  output logic              full,
  output logic              empty,
  output grp_t              head,
  output logic [QCNT_W-1:0] count
);

  grp_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];
  assign count = cnt_r;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the group
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_grp;
    end
  end

endmodule

// File: rtl/b64c_back.sv
module b64c_back
  import b64c_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  grp_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_message_done
);

  logic [1:0] idx_r, idx_nxt;
  logic       beat;
  logic       last;

  assign out_valid        = !q_empty;
  assign last             = (idx_r == head.last_idx);
  assign out_byte         = head.data[idx_r];
  assign out_run_last     = last;
  assign out_message_done = last && head.msg_end;

  assign beat = out_valid && !out_stall;
  assign pop  = beat && last;

  // Step through the beats of the head group
  always_comb begin
    idx_nxt = idx_r;
    if (beat) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// File: rtl/base64_stream_codec.sv
// Streaming Base64 codec, standard alphabet. Direction 0 encodes: every third byte
// (or a message end) closes a group that leaves as four characters, short groups
// padded with pad_char. Direction 1 decodes: every fourth character closes a group
// that leaves as one to three bytes; groups with a bad character and trailing
// partial groups leave nothing. Input beats are taken one per cycle while the
// two-group queue between the gathering front end and the output stage has room;
// the output stage sends one beat per cycle while out_stall is low, so encoding is
// limited by the single output port, as each three input bytes leave as four
// characters, and decoding takes one character per cycle. A closed group shows its
// first beat at the earliest on the cycle after the beat that closed it, later when
// groups ahead of it are still leaving. Write configuration only while idle;
// changing direction discards any partial group.
module base64_stream_codec
  import b64c_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_byte,
  input  logic                 in_message_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_run_last,
  output logic                 out_message_done
);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  grp_t              push_grp;
  grp_t              head;
  logic [QCNT_W-1:0] q_count;

  assign in_stall = q_full;

  b64c_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_byte        (in_byte),
    .in_message_end (in_message_end),
    .q_full         (q_full),
    .push           (push),
    .push_grp       (push_grp)
  );

  b64c_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_grp (push_grp),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head),
    .count    (q_count)
  );

  b64c_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_message_done (out_message_done)
  );

`ifndef NO_ASSERTIONS
  // Queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("group queue overflow");

  // A group pushed into an empty queue shows up at the output next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push && q_empty |=> out_valid)
    else $error("pushed group not presented");

  // Message end is flagged only on the last beat of a group
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done |-> out_run_last)
    else $error("message_done without run_last");
`endif

endmodule
